@@ rtl/integer_to_radix_digits_defines.svh @@
// Assertion macros for the radix digit converter.
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// Property holds in the same cycle.
`define ITRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition implies property in the next cycle.
`define ITRD_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/itrd_pkg.sv @@
// Shared types, constants and the digit-to-ASCII mapping.
package itrd_pkg;

   localparam int ValueWidth = 64;
   localparam int BaseWidth  = 6;
   localparam int DigitWidth = 6;
   localparam int CharWidth  = 7;

   localparam logic [BaseWidth-1:0]  BaseMin   = 6'd2;
   localparam logic [BaseWidth-1:0]  BaseMax   = 6'd36;
   localparam logic [BaseWidth-1:0]  BaseReset = 6'd10;
   localparam logic [DigitWidth-1:0] DigitMax  = 6'd35;
   localparam logic [DigitWidth-1:0] DecLimit  = 6'd10;
   localparam logic [CharWidth-1:0]  CharZero  = 7'd48;
   localparam logic [CharWidth-1:0]  CharAlpha = 7'd55;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_OUT
   } state_type;

   function automatic logic [CharWidth-1:0] digit_to_char(input logic [DigitWidth-1:0] d);
      logic [DigitWidth-1:0] ds;
      ds = (d > DigitMax) ? DigitMax : d;
      if (ds < DecLimit) begin
         return CharZero + CharWidth'(ds);
      end
      return CharAlpha + CharWidth'(ds);
   endfunction

endpackage

@@ rtl/itrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module itrd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/integer_to_radix_digits.sv @@
// Top level: unsigned integer to ASCII digits in a base from 2 to 36.
// Converts one value at a time. A restoring divider that retires one quotient bit per cycle
// divides the running quotient by the base; each digit's remainder goes into a digit RAM,
// least significant first. The digits are then read back most significant first, each
// with a RAM read and then an output transfer that waits for rsp_ready. An item has 1 to
// MAX_DIGITS digits. req_ready is low from the transfer of a value until its last digit is
// taken. Zero yields a single '0'. Values that need more than MAX_DIGITS digits keep only
// the low ones. The base register saturates writes to the range 2 to 36 and resets to 10.
module integer_to_radix_digits
   import itrd_pkg::*;
#(
   parameter int VALUE_BITS = 64,
   parameter int MAX_DIGITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BaseWidth-1:0]  csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ValueWidth-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CharWidth-1:0]  rsp_digit_char,
   output logic                  rsp_last
);

`include "integer_to_radix_digits_defines.svh"

   localparam int BitCntWidth = $clog2(VALUE_BITS);
   localparam int CntWidth    = $clog2(MAX_DIGITS + 1);
   localparam int AddrWidth   = $clog2(MAX_DIGITS);

   state_type                 state_ff, state_in;
   logic [BaseWidth-1:0]      base_ff, base_in;
   logic [VALUE_BITS-1:0]     quot_ff, quot_in;
   logic [DigitWidth-1:0]     rem_ff, rem_in;
   logic [BitCntWidth-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [CntWidth-1:0]       cnt_ff, cnt_in;

   logic [DigitWidth:0]       partial;
   logic                      ge;
   logic [DigitWidth-1:0]     rem_step;
   logic [VALUE_BITS-1:0]     quot_step;
   logic [CntWidth-1:0]       cnt_inc;
   logic                      digit_done;
   logic                      more_digits;
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [AddrWidth-1:0]      ram_rd_addr;
   logic [DigitWidth-1:0]     ram_rd_data;
   logic                      last_xfer;

   // Saturating base register.
   always_comb begin
      base_in = base_ff;
      if (csr_valid && csr_ready) begin
         priority if (csr_wdata < BaseMin) begin
            base_in = BaseMin;
         end else if (csr_wdata > BaseMax) begin
            base_in = BaseMax;
         end else begin
            base_in = csr_wdata;
         end
      end
   end

   // One restoring division step.
   assign partial     = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign ge          = (partial >= {1'b0, base_ff});
   assign rem_step    = ge ? DigitWidth'(partial - {1'b0, base_ff}) : DigitWidth'(partial);
   assign quot_step   = {quot_ff[VALUE_BITS-2:0], ge};
   assign cnt_inc     = cnt_ff + 1'b1;
   assign digit_done  = (bit_cnt_ff == '0);
   assign more_digits = (quot_step != '0) && (cnt_inc < CntWidth'(MAX_DIGITS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (digit_done && !more_digits) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = (cnt_ff == CntWidth'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = !reset;
            quot_in    = req_value[VALUE_BITS-1:0];
            rem_in     = '0;
            bit_cnt_in = BitCntWidth'(VALUE_BITS - 1);
            cnt_in     = '0;
         end
         ST_DIV: begin
            quot_in    = quot_step;
            rem_in     = rem_step;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (digit_done) begin
               ram_wr_en  = 1'b1;
               cnt_in     = cnt_inc;
               rem_in     = '0;
               bit_cnt_in = BitCntWidth'(VALUE_BITS - 1);
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign csr_ready      = !reset;
   assign ram_rd_addr    = AddrWidth'(cnt_ff - 1'b1);
   assign rsp_digit_char = digit_to_char(ram_rd_data);
   assign rsp_last       = (cnt_ff == CntWidth'(1));
   assign last_xfer      = rsp_valid && rsp_ready && rsp_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= BaseReset;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
   end

   itrd_ram #(
      .WIDTH (DigitWidth),
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[AddrWidth-1:0]),
      .wr_data (rem_step),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   `ITRD_ASSERT(a_busy_not_ready, !(rsp_valid && req_ready), "result pending while ready")
   `ITRD_ASSERT(a_cnt_bound, cnt_ff <= CntWidth'(MAX_DIGITS), "digit count overflow")
   `ITRD_ASSERT(a_out_has_digit, !(state_ff == ST_OUT) || (cnt_ff != '0), "output with no digit")
   `ITRD_ASSERT(a_base_range, (base_ff >= BaseMin) && (base_ff <= BaseMax), "base out of range")
   `ITRD_ASSERT_NEXT(a_last_ends, last_xfer, state_ff == ST_IDLE, "no idle after last")

endmodule
